@@ hw/rtl/raft_pkg.sv @@
package raft_pkg;

	localparam int unsigned TO_MIN = 50;
	localparam int unsigned TO_MAX = 3 * TO_MIN;
	localparam logic [7:0] INIT_TIMEOUT_RST = 8'd100;
	localparam logic [7:0] PEER_COUNT_RST = 8'd2;
	localparam logic [7:0] ELAPSED_MAX = 8'hFF;

	localparam int unsigned ADDR_BITS = 4;
	localparam int unsigned DATA_BITS = 32;

	typedef enum logic [1:0] {
		REG_SELF_ID = 2'd0,
		REG_PEER_COUNT = 2'd1,
		REG_INIT_TIMEOUT = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		ACT_HEARTBEAT = 2'd0,
		ACT_VOTE_REQ = 2'd1,
		ACT_TICK = 2'd2,
		ACT_TALLY = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ROLE_FOLLOWER = 2'd0,
		ROLE_CANDIDATE = 2'd1,
		ROLE_LEADER = 2'd2
	} role_t;

	typedef struct packed {
		logic [15:0] self_id;
		logic [7:0] peer_count;
		logic to_load;
		logic [7:0] to_value;
	} cfg_t;

	function automatic logic [7:0] clamp_timeout(input logic [7:0] v);
		logic [7:0] r;
		r = v;
		if (v < 8'(TO_MIN)) begin
			r = 8'(TO_MIN);
		end else if (v > 8'(TO_MAX)) begin
			r = 8'(TO_MAX);
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/raft_cfg.sv @@
module raft_cfg (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [raft_pkg::ADDR_BITS-1:0] paddr,
	input  logic [raft_pkg::DATA_BITS-1:0] pwdata,
	output logic [raft_pkg::DATA_BITS-1:0] prdata,
	output logic pready,
	output raft_pkg::cfg_t cfg
);

	logic [15:0] self_id_q;
	logic [7:0] peer_count_q;
	logic [7:0] init_timeout_q;
	logic wr_en;
	raft_pkg::reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite & pready;
	assign idx = raft_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			self_id_q <= '0;
			peer_count_q <= raft_pkg::PEER_COUNT_RST;
			init_timeout_q <= raft_pkg::INIT_TIMEOUT_RST;
		end else if (wr_en) begin
			case (idx)
				raft_pkg::REG_SELF_ID: self_id_q <= pwdata[15:0];
				raft_pkg::REG_PEER_COUNT: peer_count_q <= pwdata[7:0];
				raft_pkg::REG_INIT_TIMEOUT: init_timeout_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			raft_pkg::REG_SELF_ID: prdata = {16'd0, self_id_q};
			raft_pkg::REG_PEER_COUNT: prdata = {24'd0, peer_count_q};
			raft_pkg::REG_INIT_TIMEOUT: prdata = {24'd0, init_timeout_q};
			default: prdata = '0;
		endcase
	end

	assign cfg.self_id = self_id_q;
	assign cfg.peer_count = peer_count_q;
	assign cfg.to_load = wr_en && (idx == raft_pkg::REG_INIT_TIMEOUT);
	assign cfg.to_value = pwdata[7:0];

endmodule

@@ hw/rtl/raft_core.sv @@
module raft_core #(
	parameter int unsigned TERM_BITS = 32,
	parameter int unsigned ID_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  raft_pkg::cfg_t cfg,
	input  logic item_valid,
	output logic item_ready,
	input  logic [1:0] action,
	input  logic [15:0] sender_id,
	input  logic [31:0] msg_term,
	input  logic [7:0] vote_count,
	input  logic [7:0] new_timeout,
	output logic result_valid,
	input  logic result_ready,
	output logic vote_ok,
	output logic start_election,
	output logic [1:0] role,
	output logic [31:0] term_now,
	output logic leader_known,
	output logic [15:0] leader_now,
	output logic two_leaders
);

	// input stage
	logic s1_valid_q;
	raft_pkg::action_t action_s1;
	logic [ID_BITS-1:0] sender_s1;
	logic [TERM_BITS-1:0] term_s1;
	logic [7:0] votes_s1;
	logic [7:0] fresh_s1;

	// node state
	raft_pkg::role_t role_q;
	logic [TERM_BITS-1:0] term_q;
	logic lvalid_q;
	logic [ID_BITS-1:0] lid_q;
	logic [7:0] elapsed_q;
	logic [7:0] timeout_q;

	// result stage
	logic res_valid_s2;
	logic granted_s2;
	logic started_s2;
	raft_pkg::role_t role_s2;
	logic [TERM_BITS-1:0] term_s2;
	logic lvalid_s2;
	logic [ID_BITS-1:0] lid_s2;
	logic twol_s2;

	logic adv_s1;
	raft_pkg::role_t role_d;
	logic [TERM_BITS-1:0] term_d;
	logic lvalid_d;
	logic [ID_BITS-1:0] lid_d;
	logic [7:0] elapsed_d;
	logic [7:0] elapsed_inc;
	logic granted_d;
	logic started_d;
	logic twol_d;
	logic is_new;

	assign adv_s1 = s1_valid_q && (!res_valid_s2 || result_ready);
	assign item_ready = !s1_valid_q || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (item_ready) begin
			s1_valid_q <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			action_s1 <= raft_pkg::action_t'(action);
			sender_s1 <= ID_BITS'(sender_id);
			term_s1 <= TERM_BITS'(msg_term);
			votes_s1 <= vote_count;
			fresh_s1 <= new_timeout;
		end
	end

	assign elapsed_inc = (elapsed_q < raft_pkg::ELAPSED_MAX) ? elapsed_q + 8'd1 : elapsed_q;
	assign is_new = !lvalid_q || (sender_s1 != lid_q) || (term_s1 != term_q);

	always_comb begin
		role_d = role_q;
		term_d = term_q;
		lvalid_d = lvalid_q;
		lid_d = lid_q;
		elapsed_d = elapsed_q;
		granted_d = 1'b0;
		started_d = 1'b0;
		twol_d = 1'b0;
		case (action_s1)
			raft_pkg::ACT_HEARTBEAT: begin
				if (!is_new) begin
					elapsed_d = '0;
				end else if ((term_s1 > term_q) || ((term_s1 == term_q) && !lvalid_q)) begin
					term_d = term_s1;
					lid_d = sender_s1;
					lvalid_d = 1'b1;
					if (role_q == raft_pkg::ROLE_LEADER) begin
						role_d = raft_pkg::ROLE_FOLLOWER;
					end
					elapsed_d = '0;
				end else if ((role_q == raft_pkg::ROLE_FOLLOWER) && (term_s1 == term_q) &&
						(sender_s1 != lid_q) && (term_q != '0) && lvalid_q) begin
					twol_d = 1'b1;
				end
			end
			raft_pkg::ACT_VOTE_REQ: begin
				if (term_s1 > term_q) begin
					granted_d = 1'b1;
					term_d = term_s1;
					lvalid_d = 1'b0;
					role_d = raft_pkg::ROLE_FOLLOWER;
				end
				elapsed_d = '0;
			end
			raft_pkg::ACT_TICK: begin
				elapsed_d = elapsed_inc;
				if ((role_q == raft_pkg::ROLE_FOLLOWER) && (elapsed_inc >= timeout_q)) begin
					role_d = raft_pkg::ROLE_CANDIDATE;
					if (term_q != '1) begin
						term_d = term_q + TERM_BITS'(1);
					end
					lvalid_d = 1'b0;
					elapsed_d = '0;
					started_d = 1'b1;
				end
			end
			raft_pkg::ACT_TALLY: begin
				if (role_q == raft_pkg::ROLE_CANDIDATE) begin
					if (votes_s1 >= (cfg.peer_count >> 1)) begin
						role_d = raft_pkg::ROLE_LEADER;
						lvalid_d = 1'b1;
						lid_d = ID_BITS'(cfg.self_id);
					end else begin
						role_d = raft_pkg::ROLE_FOLLOWER;
						lvalid_d = 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			role_q <= raft_pkg::ROLE_FOLLOWER;
			term_q <= '0;
			lvalid_q <= 1'b0;
			lid_q <= '0;
			elapsed_q <= '0;
			timeout_q <= raft_pkg::clamp_timeout(raft_pkg::INIT_TIMEOUT_RST);
		end else begin
			if (adv_s1) begin
				role_q <= role_d;
				term_q <= term_d;
				lvalid_q <= lvalid_d;
				lid_q <= lid_d;
				elapsed_q <= elapsed_d;
			end
			if (cfg.to_load) begin
				timeout_q <= raft_pkg::clamp_timeout(cfg.to_value);
			end else if (adv_s1 && (action_s1 == raft_pkg::ACT_TALLY)) begin
				timeout_q <= raft_pkg::clamp_timeout(fresh_s1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			res_valid_s2 <= 1'b1;
		end else if (result_ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			granted_s2 <= granted_d;
			started_s2 <= started_d;
			role_s2 <= role_d;
			term_s2 <= term_d;
			lvalid_s2 <= lvalid_d;
			lid_s2 <= lid_d;
			twol_s2 <= twol_d;
		end
	end

	assign result_valid = res_valid_s2;
	assign vote_ok = granted_s2;
	assign start_election = started_s2;
	assign role = role_s2;
	assign term_now = 32'(term_s2);
	assign leader_known = lvalid_s2;
	assign leader_now = 16'(lid_s2);
	assign two_leaders = twol_s2;

	a_elect_role: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && started_d |=> res_valid_s2 && (role_s2 == raft_pkg::ROLE_CANDIDATE))
		else $error("election start without candidate role");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !adv_s1 |=> s1_valid_q)
		else $error("input stage item dropped");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(term_q) && $stable(role_q) && $stable(lvalid_q))
		else $error("state changed without an item");

	a_twol_follower: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 && twol_s2 |-> (role_s2 == raft_pkg::ROLE_FOLLOWER) && lvalid_s2)
		else $error("two leaders flagged off follower");

	a_grant_forgets: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 && granted_s2 |-> !lvalid_s2 && (role_s2 == raft_pkg::ROLE_FOLLOWER))
		else $error("granted vote kept leader");

endmodule

@@ hw/rtl/raft_election_node_unit.sv @@
// A result passes the input register, then the result register; node state updates as an
// item leaves the input register. One item per cycle unless a stalled result holds it up.
// A stalled result holds the input register; it takes a new item when empty or advancing.
// Reset (arst_n low, asynchronous): follower, term 0, no leader, timer 0,
// timeout 100 ticks, registers self_id 0, peer_count 2, initial_timeout_ms 100.
module raft_election_node_unit #(
	parameter int unsigned TERM_BITS = 32,
	parameter int unsigned ID_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [raft_pkg::ADDR_BITS-1:0] paddr,
	input  logic [raft_pkg::DATA_BITS-1:0] pwdata,
	output logic [raft_pkg::DATA_BITS-1:0] prdata,
	output logic pready,
	input  logic item_valid,
	output logic item_ready,
	input  logic [1:0] action,
	input  logic [15:0] sender_id,
	input  logic [31:0] msg_term,
	input  logic [7:0] vote_count,
	input  logic [7:0] new_timeout,
	output logic result_valid,
	input  logic result_ready,
	output logic vote_ok,
	output logic start_election,
	output logic [1:0] role,
	output logic [31:0] term_now,
	output logic leader_known,
	output logic [15:0] leader_now,
	output logic two_leaders
);

	raft_pkg::cfg_t cfg;

	raft_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	raft_core #(
		.TERM_BITS(TERM_BITS),
		.ID_BITS(ID_BITS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.action(action),
		.sender_id(sender_id),
		.msg_term(msg_term),
		.vote_count(vote_count),
		.new_timeout(new_timeout),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.vote_ok(vote_ok),
		.start_election(start_election),
		.role(role),
		.term_now(term_now),
		.leader_known(leader_known),
		.leader_now(leader_now),
		.two_leaders(two_leaders)
	);

endmodule

@@ tb/raft_election_node_unit_tb.sv @@
`timescale 1ns / 100ps

module raft_election_node_unit_tb;

	localparam int CYCLE_LIMIT = 300000;
	localparam logic [1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		raft_pkg::action_t act;
		logic [15:0] sender;
		logic [31:0] term;
		logic [7:0] votes;
		logic [7:0] fresh;
	} item_t;

	typedef struct packed {
		logic granted;
		logic started;
		raft_pkg::role_t role;
		logic [31:0] term;
		logic known;
		logic [15:0] leader;
		logic twol;
	} node_status_t;

	typedef struct packed {
		item_t stim;
		bit typed_row;
		node_status_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [raft_pkg::ADDR_BITS-1:0] paddr = '0;
	logic [raft_pkg::DATA_BITS-1:0] pwdata = '0;
	logic [raft_pkg::DATA_BITS-1:0] prdata;
	logic pready;
	logic item_valid = 1'b0;
	logic item_ready;
	logic [1:0] action = '0;
	logic [15:0] sender_id = '0;
	logic [31:0] msg_term = '0;
	logic [7:0] vote_count = '0;
	logic [7:0] new_timeout = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic vote_ok;
	logic start_election;
	logic [1:0] role;
	logic [31:0] term_now;
	logic leader_known;
	logic [15:0] leader_now;
	logic two_leaders;

	raft_election_node_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.action(action),
		.sender_id(sender_id),
		.msg_term(msg_term),
		.vote_count(vote_count),
		.new_timeout(new_timeout),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.vote_ok(vote_ok),
		.start_election(start_election),
		.role(role),
		.term_now(term_now),
		.leader_known(leader_known),
		.leader_now(leader_now),
		.two_leaders(two_leaders)
	);

	always #5 clk = ~clk;

	// node model state and register copies
	raft_pkg::role_t st_role = raft_pkg::ROLE_FOLLOWER;
	logic [31:0] st_term = '0;
	logic st_known = 1'b0;
	logic [15:0] st_leader = '0;
	logic [7:0] st_elapsed = '0;
	logic [7:0] st_timeout = raft_pkg::INIT_TIMEOUT_RST;
	logic [15:0] cf_self = '0;
	logic [7:0] cf_peers = raft_pkg::PEER_COUNT_RST;

	node_status_t pending_status[$];
	row_t script[$];
	int mismatch_count = 0;
	int sent_count = 0;
	int cycle_count = 0;
	int burst_left = 0;

	function automatic logic [7:0] bound_timeout(logic [7:0] v);
		if (v < 8'(raft_pkg::TO_MIN))
			return 8'(raft_pkg::TO_MIN);
		if (v > 8'(raft_pkg::TO_MAX))
			return 8'(raft_pkg::TO_MAX);
		return v;
	endfunction

	function automatic node_status_t node_step(item_t it);
		node_status_t s;
		s = '0;
		case (it.act)
			raft_pkg::ACT_HEARTBEAT: begin
				if (st_known && it.sender == st_leader && it.term == st_term) begin
					st_elapsed = '0;
				end else if (it.term > st_term || (it.term == st_term && !st_known)) begin
					st_term = it.term;
					st_leader = it.sender;
					st_known = 1'b1;
					if (st_role == raft_pkg::ROLE_LEADER)
						st_role = raft_pkg::ROLE_FOLLOWER;
					st_elapsed = '0;
				end else if (st_role == raft_pkg::ROLE_FOLLOWER && it.term == st_term &&
						it.sender != st_leader && st_term != 0 && st_known) begin
					s.twol = 1'b1;
				end
			end
			raft_pkg::ACT_VOTE_REQ: begin
				if (it.term > st_term) begin
					s.granted = 1'b1;
					st_term = it.term;
					st_known = 1'b0;
					st_role = raft_pkg::ROLE_FOLLOWER;
				end
				st_elapsed = '0;
			end
			raft_pkg::ACT_TICK: begin
				if (st_elapsed != raft_pkg::ELAPSED_MAX)
					st_elapsed = st_elapsed + 8'd1;
				if (st_role == raft_pkg::ROLE_FOLLOWER && st_elapsed >= st_timeout) begin
					st_role = raft_pkg::ROLE_CANDIDATE;
					if (st_term != '1)
						st_term = st_term + 32'd1;
					st_known = 1'b0;
					st_elapsed = '0;
					s.started = 1'b1;
				end
			end
			default: begin
				if (st_role == raft_pkg::ROLE_CANDIDATE) begin
					if (it.votes >= cf_peers / 2) begin
						st_role = raft_pkg::ROLE_LEADER;
						st_known = 1'b1;
						st_leader = cf_self;
					end else begin
						st_role = raft_pkg::ROLE_FOLLOWER;
						st_known = 1'b0;
					end
				end
				st_timeout = bound_timeout(it.fresh);
			end
		endcase
		s.role = st_role;
		s.term = st_term;
		s.known = st_known;
		s.leader = st_leader;
		return s;
	endfunction

	function automatic void add_row(raft_pkg::action_t a, logic [15:0] s, logic [31:0] t,
			logic [7:0] v, logic [7:0] n, bit typed_row, logic g, logic [31:0] tn,
			logic lk, logic [15:0] ln, logic tl);
		row_t r;
		r.stim = {a, s, t, v, n};
		r.typed_row = typed_row;
		r.want = {g, 1'b0, raft_pkg::ROLE_FOLLOWER, tn, lk, ln, tl};
		script = {script, r};
	endfunction

	function automatic item_t noise_item();
		item_t it;
		it.act = raft_pkg::action_t'($urandom_range(0, 3));
		it.sender = 16'($urandom);
		it.term = $urandom;
		it.votes = 8'($urandom);
		it.fresh = 8'($urandom);
		return it;
	endfunction

	task automatic send_item(item_t it, bit typed_row = 1'b0, node_status_t given = '0);
		int gap;
		node_status_t s;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				@(negedge clk);
				item_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		item_valid <= 1'b1;
		action <= it.act;
		sender_id <= it.sender;
		msg_term <= it.term;
		vote_count <= it.votes;
		new_timeout <= it.fresh;
		do @(posedge clk); while (!item_ready);
		s = node_step(it);
		if (typed_row)
			s = given;
		pending_status = {pending_status, s};
		sent_count++;
	endtask

	task automatic send_tick();
		item_t it;
		it = noise_item();
		it.act = raft_pkg::ACT_TICK;
		send_item(it);
	endtask

	// hold the sender until every result is back
	task automatic drain();
		@(negedge clk);
		item_valid <= 1'b0;
		burst_left = 0;
		while (pending_status.size() != 0) @(posedge clk);
	endtask

	task automatic reg_write(logic [1:0] idx, logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			raft_pkg::REG_SELF_ID: cf_self = data[15:0];
			raft_pkg::REG_PEER_COUNT: cf_peers = data[7:0];
			raft_pkg::REG_INIT_TIMEOUT: st_timeout = bound_timeout(data[7:0]);
			default: ;
		endcase
	endtask

	task automatic configure(logic [15:0] self_v, logic [7:0] peers_v, logic [7:0] init_v);
		reg_write(raft_pkg::REG_SELF_ID, {16'($urandom), self_v});
		reg_write(raft_pkg::REG_PEER_COUNT, {24'($urandom), peers_v});
		reg_write(raft_pkg::REG_INIT_TIMEOUT, {24'($urandom), init_v});
		reg_write(REG_SPARE, $urandom);
	endtask

	task automatic election_round(bit long_hold);
		item_t it;
		int guard;
		if (st_role == raft_pkg::ROLE_LEADER) begin
			it = noise_item();
			it.act = raft_pkg::ACT_HEARTBEAT;
			it.term = st_term + 32'd1;
			send_item(it);
		end
		guard = 0;
		while (st_role == raft_pkg::ROLE_FOLLOWER && guard < 300) begin
			send_tick();
			guard++;
		end
		// timer saturates while not a follower
		if (long_hold)
			repeat (260) send_tick();
		if ($urandom_range(0, 3) == 0) begin
			it = noise_item();
			it.act = $urandom_range(0, 1) ? raft_pkg::ACT_HEARTBEAT : raft_pkg::ACT_VOTE_REQ;
			it.term = st_term + 32'($urandom_range(0, 1));
			send_item(it);
		end
		it = noise_item();
		it.act = raft_pkg::ACT_TALLY;
		case ($urandom_range(0, 3))
			0: it.votes = 8'(cf_peers / 2 - 1);
			1: it.votes = 8'(cf_peers / 2);
			2: it.votes = 8'(cf_peers / 2 + 1);
			default: ;
		endcase
		if ($urandom_range(0, 4) != 0)
			it.fresh = 8'($urandom_range(50, 60));
		send_item(it);
	endtask

	function automatic logic [31:0] near_term();
		case ($urandom_range(0, 4))
			0: return st_term + 32'd1;
			1: return (st_term == 0) ? st_term : st_term - 32'd1;
			2: return st_term + 32'($urandom_range(2, 50));
			default: return st_term;
		endcase
	endfunction

	task automatic run_phase(int quota, bit long_hold);
		item_t it;
		int start;
		start = sent_count;
		if (long_hold)
			election_round(1'b1);
		while (sent_count - start < quota) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: election_round(1'b0);
				4, 5: begin
					repeat ($urandom_range(1, 6)) begin
						it = noise_item();
						it.act = raft_pkg::ACT_HEARTBEAT;
						case ($urandom_range(0, 3))
							0, 1: it.sender = st_leader;
							2: it.sender = cf_self;
							default: ;
						endcase
						it.term = near_term();
						send_item(it);
						if ($urandom_range(0, 2) == 0)
							send_tick();
					end
				end
				6: begin
					it = noise_item();
					it.act = raft_pkg::ACT_VOTE_REQ;
					it.term = near_term();
					send_item(it);
				end
				7: repeat ($urandom_range(1, 20)) send_tick();
				default: repeat ($urandom_range(1, 5)) send_item(noise_item());
			endcase
		end
	endtask

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin : check_results
		node_status_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_status.size() == 0) begin
				$display("%0t: result with no item outstanding", $time);
				mismatch_count++;
			end else begin
				want = pending_status.pop_front();
				compare_field("vote_ok", 32'(want.granted), 32'(vote_ok));
				compare_field("start_election", 32'(want.started), 32'(start_election));
				compare_field("role", 32'(want.role), 32'(role));
				compare_field("term_now", want.term, term_now);
				compare_field("leader_known", 32'(want.known), 32'(leader_known));
				compare_field("leader_now", 32'(want.leader), 32'(leader_now));
				compare_field("two_leaders", 32'(want.twol), 32'(two_leaders));
			end
		end
	end

	// receiver stalls in modes of random length
	int stall_left = 0;
	int stall_mode = 0;
	logic [1:0] stall_step = '0;
	always @(negedge clk) begin
		stall_step <= stall_step + 2'd1;
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(20, 200);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: result_ready <= 1'b1;
			1: result_ready <= 1'($urandom_range(0, 1));
			2: result_ready <= (stall_step != 2'b11);
			default: result_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		item_t it;
		// reset settings: self_id 0, peer_count 2, timeout 100
		add_row(raft_pkg::ACT_TICK, 16'd0, 32'd0, 8'd0, 8'd0,
			1'b1, 1'b0, 32'd0, 1'b0, 16'd0, 1'b0);
		add_row(raft_pkg::ACT_HEARTBEAT, 16'd5, 32'd0, 8'd0, 8'd0,
			1'b1, 1'b0, 32'd0, 1'b1, 16'd5, 1'b0);
		// term zero never flags two leaders
		add_row(raft_pkg::ACT_HEARTBEAT, 16'd6, 32'd0, 8'd0, 8'd0,
			1'b1, 1'b0, 32'd0, 1'b1, 16'd5, 1'b0);
		add_row(raft_pkg::ACT_VOTE_REQ, 16'd0, 32'd0, 8'd0, 8'd0,
			1'b1, 1'b0, 32'd0, 1'b1, 16'd5, 1'b0);
		add_row(raft_pkg::ACT_VOTE_REQ, 16'd0, 32'd5, 8'd0, 8'd0,
			1'b1, 1'b1, 32'd5, 1'b0, 16'd5, 1'b0);
		add_row(raft_pkg::ACT_HEARTBEAT, 16'hFFFF, 32'd5, 8'd0, 8'd0,
			1'b1, 1'b0, 32'd5, 1'b1, 16'hFFFF, 1'b0);
		add_row(raft_pkg::ACT_HEARTBEAT, 16'd1, 32'd5, 8'd0, 8'd0,
			1'b1, 1'b0, 32'd5, 1'b1, 16'hFFFF, 1'b1);
		add_row(raft_pkg::ACT_HEARTBEAT, 16'hFFFF, 32'd5, 8'd0, 8'd0,
			1'b1, 1'b0, 32'd5, 1'b1, 16'hFFFF, 1'b0);
		add_row(raft_pkg::ACT_HEARTBEAT, 16'd2, 32'd4, 8'd0, 8'd0,
			1'b1, 1'b0, 32'd5, 1'b1, 16'hFFFF, 1'b0);
		add_row(raft_pkg::ACT_TALLY, 16'd0, 32'd0, 8'd0, 8'd0,
			1'b1, 1'b0, 32'd5, 1'b1, 16'hFFFF, 1'b0);
		add_row(raft_pkg::ACT_TALLY, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF,
			1'b1, 1'b0, 32'd5, 1'b1, 16'hFFFF, 1'b0);
		add_row(raft_pkg::ACT_TALLY, 16'd0, 32'd0, 8'd0, 8'd49,
			1'b1, 1'b0, 32'd5, 1'b1, 16'hFFFF, 1'b0);
		add_row(raft_pkg::ACT_HEARTBEAT, 16'd0, 32'd6, 8'd0, 8'd0,
			1'b1, 1'b0, 32'd6, 1'b1, 16'd0, 1'b0);
		add_row(raft_pkg::ACT_VOTE_REQ, 16'd0, 32'd6, 8'd0, 8'd0,
			1'b1, 1'b0, 32'd6, 1'b1, 16'd0, 1'b0);
		add_row(raft_pkg::ACT_TICK, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF,
			1'b1, 1'b0, 32'd6, 1'b1, 16'd0, 1'b0);
		add_row(raft_pkg::ACT_TALLY, 16'd9, 32'd3, 8'd1, 8'd150,
			1'b0, 1'b0, 32'd0, 1'b0, 16'd0, 1'b0);
		add_row(raft_pkg::ACT_TALLY, 16'd9, 32'd3, 8'd1, 8'd151,
			1'b0, 1'b0, 32'd0, 1'b0, 16'd0, 1'b0);
		add_row(raft_pkg::ACT_VOTE_REQ, 16'd7, 32'h0000_0100, 8'd0, 8'd50,
			1'b0, 1'b0, 32'd0, 1'b0, 16'd0, 1'b0);
		add_row(raft_pkg::ACT_HEARTBEAT, 16'd7, 32'h0000_0100, 8'd0, 8'd50,
			1'b0, 1'b0, 32'd0, 1'b0, 16'd0, 1'b0);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i])
			send_item(script[i].stim, script[i].typed_row, script[i].want);

		drain();
		configure(16'hFFFF, 8'd0, 8'd50);
		run_phase(180, 1'b0);
		drain();
		configure(16'h0000, 8'd255, 8'd0);
		run_phase(180, 1'b1);
		drain();
		configure(16'($urandom), 8'($urandom_range(1, 9)), 8'd255);
		run_phase(180, 1'b0);
		drain();
		configure(16'($urandom), 8'd2, 8'd150);
		run_phase(180, 1'b0);

		// term saturation at the top of the range
		drain();
		configure(16'($urandom), 8'd3, 8'd50);
		it = noise_item();
		it.act = raft_pkg::ACT_HEARTBEAT;
		it.term = 32'hFFFF_FFFF;
		send_item(it);
		election_round(1'b0);
		election_round(1'b0);
		repeat (10) send_item(noise_item());

		drain();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
